// File: rtl/fcr_pkg.sv
package fcr_pkg;

  localparam int MAX_W     = 64;
  localparam int MAX_H     = 64;
  localparam int ROW_AW    = $clog2(MAX_H);
  localparam int CRD_W     = 10;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W     = 6;
  localparam int LIM_W     = 13;
  localparam int BIT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic disc_init;
    logic disc_next;
    logic row_init;
    logic search_step;
    logic mem_wr;
    logic row_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic disc_empty;
    logic disc_last;
    logic row_last;
    logic search_last;
  } sts_t;

endpackage

// File: rtl/fcr_if.sv
interface fcr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] left_x;
  logic [7:0] bottom_y;
  logic [6:0] diameter;
  logic [5:0] row_index;

  modport source (output valid, req_type, left_x, bottom_y, diameter, row_index, input ready);
  modport sink   (input valid, req_type, left_x, bottom_y, diameter, row_index, output ready);
endinterface

interface fcr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_bits;
  logic        was_read;

  modport source (output valid, row_bits, was_read, input ready);
  modport sink   (input valid, row_bits, was_read, output ready);
endinterface

// File: rtl/fcr_ctrl.sv
module fcr_ctrl import fcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_req_type,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t st,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_DISC = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_SRCH = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_req_type ? S_RDI : S_DISC;
        end
      end
      S_RDI: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DISC: begin
        if (st.d_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.disc_init = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (!st.disc_empty) begin
          state_nxt = S_ROW;
        end else if (st.disc_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.disc_next = 1'b1;
          state_nxt     = S_DISC;
        end
      end
      S_ROW: begin
        cmd.row_init = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_SRCH: begin
        cmd.search_step = 1'b1;
        if (st.search_last) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (!st.row_last) begin
          cmd.row_next = 1'b1;
          state_nxt    = S_ROW;
        end else if (st.disc_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.disc_next = 1'b1;
          state_nxt     = S_DISC;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/fcr_dpath.sv
module fcr_dpath import fcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_req_type,
  input  logic [7:0]           in_left_x,
  input  logic [7:0]           in_bottom_y,
  input  logic [6:0]           in_diameter,
  input  logic [5:0]           in_row_index,
  input  cmd_t                 cmd,
  output sts_t                 st,
  output logic [MAX_W-1:0]     out_row_bits,
  output logic                 out_was_read
);

  // config registers
  logic [CFG_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] w_act, h_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_W);
      height_r <= CFG_W'(MAX_H);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  assign w_act = (width_r > CFG_W'(MAX_W)) ? CFG_W'(MAX_W) : width_r;
  assign h_act = (height_r > CFG_W'(MAX_H)) ? CFG_W'(MAX_H) : height_r;

  // request fields
  logic              req_r;
  logic [7:0]        lx_r, by_r;
  logic [6:0]        d_r;
  logic [ROW_AW-1:0] idx_r;
  logic [1:0]        disc_r;

  // disc and row state
  logic signed [CRD_W-1:0] cx_r, cy_r, j_r, j_end_r;
  logic [LIM_W-1:0]        lim_r, t_r;
  logic [RAD_W-1:0]        k_r;
  logic [BIT_W-1:0]        bit_r;
  logic                    disc_empty_r;

  // disc setup
  logic [RAD_W-1:0]        r_half, rad_n;
  logic                    offx, offy;
  logic signed [CRD_W-1:0] lx_s, by_s, cx_n, cy_n, rad_s, lo_j, hi_j, hmax, j_start, j_stop;
  logic [RAD_W:0]          rp1;
  logic [LIM_W-1:0]        lim_prod;

  always_comb begin
    r_half   = d_r[6:1];
    rad_n    = d_r[0] ? r_half : r_half - RAD_W'(1);
    offx     = (disc_r == 2'd1) || (disc_r == 2'd2);
    offy     = (disc_r == 2'd2) || (disc_r == 2'd3);
    lx_s     = signed'({{(CRD_W-8){lx_r[7]}}, lx_r});
    by_s     = signed'({{(CRD_W-8){by_r[7]}}, by_r});
    rad_s    = signed'({{(CRD_W-RAD_W){1'b0}}, rad_n});
    cx_n     = lx_s + signed'({{(CRD_W-RAD_W){1'b0}}, r_half})
               - signed'({{(CRD_W-1){1'b0}}, offx});
    cy_n     = by_s + signed'({{(CRD_W-RAD_W){1'b0}}, r_half})
               - signed'({{(CRD_W-1){1'b0}}, offy});
    lo_j     = cy_n - rad_s;
    hi_j     = cy_n + rad_s;
    hmax     = signed'({{(CRD_W-CFG_W){1'b0}}, h_act}) - signed'(CRD_W'(1));
    j_start  = lo_j[CRD_W-1] ? '0 : lo_j;
    j_stop   = (hi_j > hmax) ? hmax : hi_j;
    rp1      = {1'b0, rad_n} + (RAD_W+1)'(1);
    lim_prod = LIM_W'(rp1) * LIM_W'(rp1);
  end

  // row setup
  logic signed [CRD_W-1:0] dy;
  logic [CRD_W-1:0]        dy_abs;
  logic [2*RAD_W-1:0]      dy2;

  always_comb begin
    dy     = j_r - cy_r;
    dy_abs = dy[CRD_W-1] ? unsigned'(-dy) : unsigned'(dy);
    dy2    = (2*RAD_W)'(dy_abs[RAD_W-1:0]) * (2*RAD_W)'(dy_abs[RAD_W-1:0]);
  end

  // half-width search, one bit per cycle
  logic [RAD_W-1:0]   trial;
  logic [2*RAD_W-1:0] trial_sq;

  always_comb begin
    trial    = k_r | (RAD_W'(1) << bit_r);
    trial_sq = (2*RAD_W)'(trial) * (2*RAD_W)'(trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      lx_r   <= in_left_x;
      by_r   <= in_bottom_y;
      d_r    <= in_diameter;
      idx_r  <= in_row_index;
      disc_r <= '0;
    end
    if (cmd.disc_next) begin
      disc_r <= disc_r + 2'd1;
    end
    if (cmd.disc_init) begin
      cx_r         <= cx_n;
      cy_r         <= cy_n;
      lim_r        <= lim_prod;
      j_r          <= j_start;
      j_end_r      <= j_stop;
      disc_empty_r <= (j_start > j_stop);
    end
    if (cmd.row_next) begin
      j_r <= j_r + signed'(CRD_W'(1));
    end
    if (cmd.row_init) begin
      t_r   <= lim_r - LIM_W'(dy2);
      k_r   <= '0;
      bit_r <= BIT_W'(RAD_W - 1);
    end
    if (cmd.search_step) begin
      if (LIM_W'(trial_sq) < t_r) begin
        k_r <= trial;
      end
      bit_r <= bit_r - BIT_W'(1);
    end
  end

  // canvas memory, rows cleared through valid bits
  logic [MAX_W-1:0]  mem [MAX_H];
  logic [MAX_H-1:0]  vld_r;
  logic [MAX_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic [MAX_W-1:0]  old_row, mask;
  logic signed [CRD_W-1:0] lo_c, hi_c, col;

  assign rd_addr = cmd.rd_issue ? idx_r : j_r[ROW_AW-1:0];
  assign wr_addr = j_r[ROW_AW-1:0];
  assign old_row = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    lo_c = cx_r - signed'({{(CRD_W-RAD_W){1'b0}}, k_r});
    hi_c = cx_r + signed'({{(CRD_W-RAD_W){1'b0}}, k_r});
    col  = '0;
    mask = '0;
    for (int i = 0; i < MAX_W; i++) begin
      col     = signed'(CRD_W'(i));
      mask[i] = (col >= lo_c) && (col <= hi_c) && (CFG_W'(i) < w_act);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue || cmd.row_init) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.mem_wr) begin
      mem[wr_addr] <= old_row | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.mem_wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_bits <= req_r ? old_row : '0;
      out_was_read <= req_r;
    end
  end

  assign st.d_zero      = (d_r == 7'd0);
  assign st.disc_empty  = disc_empty_r;
  assign st.disc_last   = d_r[0] || (disc_r == 2'd3);
  assign st.row_last    = (j_r == j_end_r);
  assign st.search_last = (bit_r == '0);

endmodule

// File: rtl/filled_circle_raster_unit.sv
// filled circle raster unit
// keeps a 64 x 64 one-bit canvas, cleared at reset through per-row valid bits
// (no clearing pass: the block takes items from the first cycle after reset)
// in_ch: one item per request, accepted when valid and ready are high together
//   req_type 0 draws a filled circle, 1 reads the row at row_index
// out_ch: exactly one item per request; row_bits holds the row on a read and
//   zero on a draw, was_read tells the two apart
// cfg port: cfg_we writes cfg_wdata into canvas width (index 0) or height (1);
//   the user is to write it only while the block is idle, which the block
//   does not enforce; reset values are 64 and 64
// a read issues one canvas read and then loads the result; a draw sets up and
//   checks each disc (one for odd and four for even diameters) and per clipped row
//   runs the 6-step half-width search plus one read-modify-write of the canvas memory
// one request is in work at a time; in_ch.ready rises again as soon as the
//   result sits in the output register, so the next request is taken while
//   a stalled receiver still holds the previous result
// a result waits in the output register for as long as out_ch.ready is low
module filled_circle_raster_unit import fcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fcr_in_if.sink               in_ch,
  fcr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cmd_t cmd;
  sts_t st;

  fcr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .st          (st),
    .cmd         (cmd)
  );

  fcr_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_req_type  (in_ch.req_type),
    .in_left_x    (in_ch.left_x),
    .in_bottom_y  (in_ch.bottom_y),
    .in_diameter  (in_ch.diameter),
    .in_row_index (in_ch.row_index),
    .cmd          (cmd),
    .st           (st),
    .out_row_bits (out_ch.row_bits),
    .out_was_read (out_ch.was_read)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready && !cmd.out_load)
    else $error("request accepted while a request is in work");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_ch.valid || out_ch.ready)
    else $error("result overwrites a pending result");

  a_single_datapath_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_issue, cmd.disc_init, cmd.row_init,
              cmd.search_step, cmd.mem_wr, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule
